>>> hw/rtl/gls_pkg.sv
// Shared types, constants and codes of the grid line-of-sight checker.
// No dependencies; imported by every module of the block but gls_ram.
`default_nettype none
package gls_pkg;

    localparam int COORD_W    = 8;   // coordinate field width
    localparam int COST_W     = 8;   // cost byte width
    localparam int CRD_W      = 9;   // checked-cell coordinate, reaches 256
    localparam int ADR_SRC_W  = 10;  // coordinate widened for address slicing
    localparam int EXT_W      = 11;  // compare width, holds a grid size of 1024
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam int DEF_GRID_COLS = 256;
    localparam int DEF_GRID_ROWS = 256;

    localparam logic [COST_W-1:0]     RST_COST_THRESHOLD = 8'd128;
    localparam logic [CFG_DATA_W-1:0] RST_MAP_WIDTH      = 9'd256;
    localparam logic [CFG_DATA_W-1:0] RST_MAP_HEIGHT     = 9'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_COST_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT     = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] from_x;
        logic [COORD_W-1:0] from_y;
        logic [COORD_W-1:0] to_x;
        logic [COORD_W-1:0] to_y;
        logic [COST_W-1:0]  cell_cost;
    } t_item;

    typedef struct packed {
        logic visible;
        logic left_map;
    } t_result;

    typedef struct packed {
        logic [CRD_W-1:0] x;
        logic [CRD_W-1:0] y;
    } t_cell;

    typedef struct packed {
        logic outside;  // beyond the configured map
        logic in_grid;  // inside the physical grid store
    } t_probe_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_CROSS_EVAL,
        S_MAIN,
        S_MAIN_EVAL,
        S_SIDE0_EVAL,
        S_SIDE1_EVAL
    } t_state;

endpackage
`default_nettype wire

>>> hw/rtl/gls_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module gls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> hw/rtl/gls_probe.sv
// Cell probe: map bounds check, grid bounds check and grid address of one cell.
// Depends on gls_pkg.
`default_nettype none
module gls_probe
    import gls_pkg::*;
#(
    parameter int GRID_COLS = DEF_GRID_COLS,
    parameter int GRID_ROWS = DEF_GRID_ROWS
) (
    input  wire t_cell                                             i_cell,
    input  wire logic [CFG_DATA_W-1:0]                             i_map_width,
    input  wire logic [CFG_DATA_W-1:0]                             i_map_height,
    output t_probe_rsp                                             o_rsp,
    output logic [$clog2(GRID_COLS)+$clog2(GRID_ROWS)-1:0]         o_addr
);

    localparam int XW = $clog2(GRID_COLS);
    localparam int YW = $clog2(GRID_ROWS);

    logic [EXT_W-1:0]     w_mw, w_mh, w_weff, w_heff, w_x, w_y;
    logic [ADR_SRC_W-1:0] w_xa, w_ya;

    always_comb begin
        w_mw   = EXT_W'(i_map_width);
        w_mh   = EXT_W'(i_map_height);
        // clip the configured map to the physical grid
        w_weff = (w_mw < EXT_W'(GRID_COLS)) ? w_mw : EXT_W'(GRID_COLS);
        w_heff = (w_mh < EXT_W'(GRID_ROWS)) ? w_mh : EXT_W'(GRID_ROWS);
        w_x    = EXT_W'(i_cell.x);
        w_y    = EXT_W'(i_cell.y);
        o_rsp.outside = (w_x >= w_weff) || (w_y >= w_heff);
        o_rsp.in_grid = (w_x < EXT_W'(GRID_COLS)) && (w_y < EXT_W'(GRID_ROWS));
        w_xa   = ADR_SRC_W'(i_cell.x);
        w_ya   = ADR_SRC_W'(i_cell.y);
        o_addr = {w_ya[YW-1:0], w_xa[XW-1:0]};
    end

endmodule
`default_nettype wire

>>> hw/rtl/gls_walk.sv
// Line walk sequencer: error accumulator, cell order and result register.
// Depends on gls_pkg; drives the shared cell probe and the grid RAM.
`default_nettype none
module gls_walk
    import gls_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire t_item             i_item,
    input  wire logic [COST_W-1:0] i_thr,
    input  wire logic [COST_W-1:0] i_rdata,
    input  wire t_probe_rsp        i_probe,
    output t_cell                  o_cell,
    output logic                   o_ram_we,
    output logic                   o_res_valid,
    output t_result                o_result
);

    t_state r_state, n_state;
    logic [COORD_W-1:0] r_a, n_a, r_aend, n_aend, r_b, n_b;
    logic [COORD_W-1:0] r_da, n_da, r_db, n_db, r_f, n_f;
    logic r_sa_neg, n_sa_neg, r_sb_neg, n_sb_neg, r_swap, n_swap;
    logic r_left, n_left, r_pend_out, n_pend_out;
    logic r_res_valid, n_res_valid;
    t_result r_result, n_result;

    logic               w_xneg, w_yneg, w_swp;
    logic [COORD_W-1:0] w_adx, w_ady;
    logic [CRD_W-1:0]   w_maj, w_mnr;
    logic               w_moff;
    logic [COORD_W:0]   w_f1;
    logic               w_blocked, w_left_now;
    logic [COORD_W-1:0] w_a_adv, w_b_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_aend     <= n_aend;
        r_b        <= n_b;
        r_da       <= n_da;
        r_db       <= n_db;
        r_f        <= n_f;
        r_sa_neg   <= n_sa_neg;
        r_sb_neg   <= n_sb_neg;
        r_swap     <= n_swap;
        r_left     <= n_left;
        r_pend_out <= n_pend_out;
        r_result   <= n_result;
    end

    always_comb begin
        // query set-up terms
        w_xneg = i_item.to_x < i_item.from_x;
        w_yneg = i_item.to_y < i_item.from_y;
        w_adx  = w_xneg ? (i_item.from_x - i_item.to_x) : (i_item.to_x - i_item.from_x);
        w_ady  = w_yneg ? (i_item.from_y - i_item.to_y) : (i_item.to_y - i_item.from_y);
        w_swp  = w_adx < w_ady;

        // minor offset of the cell to probe in this state
        case (r_state)
            S_STEP:       w_moff = (r_db == '0) ? 1'b0 : !r_sb_neg;
            S_MAIN:       w_moff = !r_sb_neg;
            S_SIDE0_EVAL: w_moff = 1'b1;
            default:      w_moff = 1'b0;
        endcase
        w_maj = CRD_W'(r_a) + CRD_W'(!r_sa_neg);
        w_mnr = CRD_W'(r_b) + CRD_W'(w_moff);
        if (r_state == S_IDLE) begin
            o_cell.x = CRD_W'(i_item.from_x);
            o_cell.y = CRD_W'(i_item.from_y);
        end else if (r_swap) begin
            o_cell.x = w_mnr;
            o_cell.y = w_maj;
        end else begin
            o_cell.x = w_maj;
            o_cell.y = w_mnr;
        end

        w_f1       = {1'b0, r_f} + {1'b0, r_db};
        w_blocked  = r_pend_out || (i_rdata >= i_thr);
        w_left_now = r_left || r_pend_out;
        w_a_adv    = r_sa_neg ? (r_a - 1'b1) : (r_a + 1'b1);
        w_b_adv    = r_sb_neg ? (r_b - 1'b1) : (r_b + 1'b1);

        n_state     = r_state;
        n_a         = r_a;
        n_aend      = r_aend;
        n_b         = r_b;
        n_da        = r_da;
        n_db        = r_db;
        n_f         = r_f;
        n_sa_neg    = r_sa_neg;
        n_sb_neg    = r_sb_neg;
        n_swap      = r_swap;
        n_left      = r_left;
        n_pend_out  = r_pend_out;
        n_res_valid = 1'b0;
        n_result    = r_result;
        o_ram_we    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_item.op == OP_WRITE) begin
                        // store now, acknowledge on the next cycle
                        o_ram_we    = i_probe.in_grid;
                        n_res_valid = 1'b1;
                        n_result    = '0;
                    end else begin
                        n_swap   = w_swp;
                        n_a      = w_swp ? i_item.from_y : i_item.from_x;
                        n_aend   = w_swp ? i_item.to_y   : i_item.to_x;
                        n_b      = w_swp ? i_item.from_x : i_item.from_y;
                        n_sa_neg = w_swp ? w_yneg : w_xneg;
                        n_sb_neg = w_swp ? w_xneg : w_yneg;
                        n_da     = w_swp ? w_ady : w_adx;
                        n_db     = w_swp ? w_adx : w_ady;
                        n_f      = '0;
                        n_left   = 1'b0;
                        n_state  = S_STEP;
                    end
                end
            end
            S_STEP: begin
                if (r_a == r_aend) begin
                    n_res_valid       = 1'b1;
                    n_result.visible  = 1'b1;
                    n_result.left_map = r_left;
                    n_state           = S_IDLE;
                end else if (r_db == '0) begin
                    n_pend_out = i_probe.outside;
                    n_state    = S_SIDE0_EVAL;
                end else if (w_f1 >= {1'b0, r_da}) begin
                    // row crossing: check the cell before it
                    n_f        = COORD_W'(w_f1 - {1'b0, r_da});
                    n_pend_out = i_probe.outside;
                    n_state    = S_CROSS_EVAL;
                end else begin
                    n_f     = w_f1[COORD_W-1:0];
                    n_state = S_MAIN;
                end
            end
            S_CROSS_EVAL: begin
                n_left = w_left_now;
                if (w_blocked) begin
                    n_res_valid       = 1'b1;
                    n_result.visible  = 1'b0;
                    n_result.left_map = w_left_now;
                    n_state           = S_IDLE;
                end else begin
                    n_b     = w_b_adv;
                    n_state = S_MAIN;
                end
            end
            S_MAIN: begin
                if (r_f != '0) begin
                    n_pend_out = i_probe.outside;
                    n_state    = S_MAIN_EVAL;
                end else begin
                    n_a     = w_a_adv;
                    n_state = S_STEP;
                end
            end
            S_MAIN_EVAL: begin
                n_left = w_left_now;
                if (w_blocked) begin
                    n_res_valid       = 1'b1;
                    n_result.visible  = 1'b0;
                    n_result.left_map = w_left_now;
                    n_state           = S_IDLE;
                end else begin
                    n_a     = w_a_adv;
                    n_state = S_STEP;
                end
            end
            S_SIDE0_EVAL: begin
                n_left = w_left_now;
                if (w_blocked) begin
                    // first side blocked: try the other side
                    n_pend_out = i_probe.outside;
                    n_state    = S_SIDE1_EVAL;
                end else begin
                    n_a     = w_a_adv;
                    n_state = S_STEP;
                end
            end
            S_SIDE1_EVAL: begin
                n_left = w_left_now;
                if (w_blocked) begin
                    n_res_valid       = 1'b1;
                    n_result.visible  = 1'b0;
                    n_result.left_map = w_left_now;
                    n_state           = S_IDLE;
                end else begin
                    n_a     = w_a_adv;
                    n_state = S_STEP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_result    = r_result;

endmodule
`default_nettype wire

>>> hw/rtl/grid_line_of_sight_check.sv
// Top level of the grid line-of-sight checker: configuration registers,
// cost grid RAM, cell probe and walk sequencer. Depends on gls_pkg, gls_ram,
// gls_probe and gls_walk.
`default_nettype none
// A transaction is taken at a rising edge with start high and busy low. A
// write transaction stores one cost byte (cells beyond the grid are dropped)
// and is acknowledged with visible = 0, left_map = 0 in the next cycle; busy
// never rises for it, so writes may follow back to back. A query transaction
// walks the line between its two corners along the major axis, one grid
// cell probe at a time through a single registered-read RAM port. Each major
// step is a step decision, then one probe and evaluate for a row crossing and
// one for the cell beside the walk, or up to two side probes on an axial
// line. The walk stops at the first blocked cell. The result is shown for
// exactly one cycle with o_result_valid high; the receiver cannot stall it,
// so take it on that cycle. Cells outside the configured map count as
// blocked and set left_map. Grid cells read by a query must have been
// written first: there is no clearing pass. Write configuration only while
// busy is low.
module grid_line_of_sight_check
    import gls_pkg::*;
#(
    parameter int GRID_COLS = DEF_GRID_COLS,
    parameter int GRID_ROWS = DEF_GRID_ROWS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_item                 i_item,
    output logic                       o_result_valid,
    output t_result                    o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW    = $clog2(GRID_COLS) + $clog2(GRID_ROWS);
    localparam int DEPTH = 1 << AW;

    logic [COST_W-1:0]     r_cost_threshold;
    logic [CFG_DATA_W-1:0] r_map_width;
    logic [CFG_DATA_W-1:0] r_map_height;

    t_cell             w_cell;
    t_probe_rsp        w_probe;
    logic [AW-1:0]     w_addr;
    logic              w_ram_we;
    logic [COST_W-1:0] w_rdata;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cost_threshold <= RST_COST_THRESHOLD;
            r_map_width      <= RST_MAP_WIDTH;
            r_map_height     <= RST_MAP_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COST_THRESHOLD: r_cost_threshold <= i_cfg_data[COST_W-1:0];
                CFG_MAP_WIDTH:      r_map_width      <= i_cfg_data;
                CFG_MAP_HEIGHT:     r_map_height     <= i_cfg_data;
                default:            r_map_width      <= r_map_width;
            endcase
        end
    end

    // one probe serves both the write address and every query cell
    gls_probe #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_probe (
        .i_cell       (w_cell),
        .i_map_width  (r_map_width),
        .i_map_height (r_map_height),
        .o_rsp        (w_probe),
        .o_addr       (w_addr)
    );

    // cost grid, read data arrives on the cycle after the probe
    gls_ram #(
        .WIDTH (COST_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_addr),
        .i_wdata (i_item.cell_cost),
        .o_rdata (w_rdata)
    );

    gls_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_item      (i_item),
        .i_thr       (r_cost_threshold),
        .i_rdata     (w_rdata),
        .i_probe     (w_probe),
        .o_cell      (w_cell),
        .o_ram_we    (w_ram_we),
        .o_res_valid (o_result_valid),
        .o_result    (o_result)
    );

endmodule
`default_nettype wire
